>>> rtl/core/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define EPA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, disabled while in reset.
`define EPA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

>>> rtl/core/epa_pkg.sv
// Types and constants of the even port allocator.
`timescale 1ns / 1ps
`default_nettype none

package epa_pkg;

    localparam int PORT_W = 16;
    localparam int RND_W  = 32;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 24;

    localparam logic KIND_ACQUIRE = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic hit;
        logic last;
        logic wrap_end;
    } scan_ev_t;

endpackage

`default_nettype wire

>>> rtl/core/epa_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module epa_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/epa_div.sv
// Bit-serial remainder unit: 32-bit dividend modulo 16-bit divisor.
`timescale 1ns / 1ps
`default_nettype none

module epa_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [epa_pkg::RND_W-1:0] dividend,
    input  wire logic [epa_pkg::PORT_W-1:0] divisor,
    output logic                           done,
    output logic [epa_pkg::PORT_W-1:0]     remainder
);
    import epa_pkg::*;

    localparam int CNT_W = $clog2(RND_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [RND_W-1:0]  dvd_reg, dvd_next;
    logic [PORT_W-1:0] dsr_reg, dsr_next;
    logic [PORT_W-1:0] rem_reg, rem_next;
    logic [PORT_W:0]   trial;
    logic [PORT_W:0]   diff;

    always_comb begin
        trial     = {rem_reg, dvd_reg[RND_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = (trial >= {1'b0, dsr_reg}) ? diff[PORT_W-1:0] : trial[PORT_W-1:0];
            dvd_next = {dvd_reg[RND_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(RND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> rtl/core/even_port_allocator.sv
// Top level of the even port allocator: sequencer, table scan and output register.
//
// Usage: s_tvalid/s_tready/s_tdata/s_tuser carry one request; s_tuser is the
// kind (0 acquire, 1 release). m_tvalid/m_tready/m_tdata return one result
// per request: chosen port and status.
// After reset the table is cleared by a pass over all PORT_SLOTS slots;
// s_tready stays low until it ends. One request is worked on at a time, and
// s_tready is high only while the block is idle.
// An acquire over a range first runs the bit-serial remainder unit, then each
// probe of a candidate port scans the table through the RAM read port, one
// slot per cycle, with about PORT_SLOTS + 1 probes at most. A one-port
// acquire or a release is one scan.
// A result waits in the output register while m_tready is low; the next
// request is taken meanwhile, and its result holds until the register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module even_port_allocator #(
    parameter int PORT_SLOTS = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // range_start[15:0], range_end[31:16], random_value[63:32], release_port[79:64]
    input  wire logic [epa_pkg::IN_DATA_W-1:0] s_tdata,
    // kind[0]
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // chosen_port[15:0], status[17:16], zero[23:18]
    output logic [epa_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import epa_pkg::*;

    localparam int SLOT_W = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
    localparam int ENT_W  = PORT_W + 1;

    state_t state_reg, state_next;

    logic [PORT_W-1:0] in_start, in_end, in_rel;
    logic [RND_W-1:0]  in_rnd;
    logic              s_fire;

    logic              kind_reg, kind_next;
    logic              onep_reg, onep_next;
    logic [PORT_W-1:0] lo_reg, lo_next;
    logic [PORT_W-1:0] hi_reg, hi_next;
    logic [PORT_W-1:0] key_reg, key_next;
    logic [PORT_W-1:0] first_reg, first_next;
    logic [PORT_W-1:0] wrap_reg, wrap_next;
    logic [SLOT_W:0]   cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic [SLOT_W-1:0] pidx_reg, pidx_next;
    logic              ffound_reg, ffound_next;
    logic [SLOT_W-1:0] fidx_reg, fidx_next;
    logic [PORT_W-1:0] res_port_reg, res_port_next;
    status_t           res_st_reg, res_st_next;
    logic              m_valid_reg, m_valid_next;
    logic [PORT_W-1:0] m_port_reg, m_port_next;
    status_t           m_st_reg, m_st_next;

    logic              div_start, div_done;
    logic [PORT_W-1:0] div_rem;
    logic [PORT_W-1:0] first_sum, first_even;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr, ram_raddr;
    logic [ENT_W-1:0]  ram_wdata, ram_rdata;

    logic              ent_valid;
    logic [PORT_W-1:0] ent_port;
    logic [PORT_W:0]   step_sum;
    logic [PORT_W-1:0] probe_next;
    logic              free_avail;
    logic [SLOT_W-1:0] free_slot;
    logic              issue;
    logic              load_out;
    scan_ev_t          ev;

    assign in_start = s_tdata[15:0];
    assign in_end   = s_tdata[31:16];
    assign in_rnd   = s_tdata[63:32];
    assign in_rel   = s_tdata[79:64];
    assign s_fire   = s_tvalid && s_tready;

    epa_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (in_rnd),
        .divisor   (hi_next - lo_next),
        .done      (div_done),
        .remainder (div_rem)
    );

    epa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (PORT_SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ent_valid  = ram_rdata[PORT_W];
    assign ent_port   = ram_rdata[PORT_W-1:0];
    assign first_sum  = lo_reg + div_rem;
    assign first_even = first_sum + {{(PORT_W-1){1'b0}}, first_sum[0]};
    assign step_sum   = {1'b0, key_reg} + (PORT_W+1)'(2);
    assign probe_next = (step_sum > {1'b0, hi_reg}) ? wrap_reg : step_sum[PORT_W-1:0];
    assign free_avail = ffound_reg || (pend_reg && !ent_valid);
    assign free_slot  = ffound_reg ? fidx_reg : pidx_reg;
    assign issue      = cnt_reg < (SLOT_W+1)'(PORT_SLOTS);
    assign load_out   = (state_reg == S_RESULT) && (!m_valid_reg || m_tready);

    always_comb begin
        ev.hit      = pend_reg && ent_valid && (ent_port == key_reg) && !onep_reg;
        ev.last     = pend_reg && (pidx_reg == SLOT_W'(PORT_SLOTS - 1));
        ev.wrap_end = probe_next == first_reg;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (cnt_reg == (SLOT_W+1)'(PORT_SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    if (s_tuser == KIND_ACQUIRE && in_start != in_end) begin
                        state_next = S_DIV;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (ev.hit) begin
                    if (kind_reg == KIND_RELEASE || ev.wrap_end) begin
                        state_next = S_RESULT;
                    end
                end else if (ev.last) begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        kind_next     = kind_reg;
        onep_next     = onep_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        key_next      = key_reg;
        first_next    = first_reg;
        wrap_next     = wrap_reg;
        cnt_next      = cnt_reg;
        pend_next     = 1'b0;
        pidx_next     = pidx_reg;
        ffound_next   = ffound_reg;
        fidx_next     = fidx_reg;
        res_port_next = res_port_reg;
        res_st_next   = res_st_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_port_next   = m_port_reg;
        m_st_next     = m_st_reg;
        div_start     = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = cnt_reg[SLOT_W-1:0];
        ram_wdata     = '0;
        ram_raddr     = cnt_reg[SLOT_W-1:0];
        s_tready      = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            S_IDLE: begin
                s_tready    = 1'b1;
                cnt_next    = '0;
                ffound_next = 1'b0;
                if (s_fire) begin
                    kind_next = s_tuser;
                    if (in_start > in_end) begin
                        lo_next = in_end;
                        hi_next = in_start;
                    end else begin
                        lo_next = in_start;
                        hi_next = in_end;
                    end
                    onep_next = (s_tuser == KIND_ACQUIRE) && (in_start == in_end);
                    key_next  = (s_tuser == KIND_RELEASE) ? in_rel : in_start;
                    div_start = (s_tuser == KIND_ACQUIRE) && (in_start != in_end);
                end
            end
            S_DIV: begin
                if (div_done) begin
                    key_next   = first_even;
                    first_next = first_even;
                    wrap_next  = lo_reg + {{(PORT_W-1){1'b0}}, lo_reg[0]};
                end
            end
            S_SCAN: begin
                if (pend_reg && !ent_valid && !ffound_reg) begin
                    ffound_next = 1'b1;
                    fidx_next   = pidx_reg;
                end
                if (issue) begin
                    pend_next = 1'b1;
                    pidx_next = cnt_reg[SLOT_W-1:0];
                    cnt_next  = cnt_reg + 1'b1;
                end
                if (ev.hit) begin
                    pend_next = 1'b0;
                    cnt_next  = '0;
                    if (kind_reg == KIND_RELEASE) begin
                        ram_we        = 1'b1;
                        ram_waddr     = pidx_reg;
                        ram_wdata     = '0;
                        res_port_next = key_reg;
                        res_st_next   = ST_OK;
                    end else if (ev.wrap_end) begin
                        res_port_next = '0;
                        res_st_next   = ST_NO_FREE;
                    end else begin
                        key_next = probe_next;
                    end
                end else if (ev.last) begin
                    if (kind_reg == KIND_RELEASE) begin
                        res_port_next = key_reg;
                        res_st_next   = ST_NOT_FOUND;
                    end else if (key_reg == '0 && !onep_reg) begin
                        res_port_next = '0;
                        res_st_next   = ST_OK;
                    end else if (free_avail) begin
                        ram_we        = 1'b1;
                        ram_waddr     = free_slot;
                        ram_wdata     = {1'b1, key_reg};
                        res_port_next = key_reg;
                        res_st_next   = ST_OK;
                    end else begin
                        res_port_next = '0;
                        res_st_next   = ST_FULL;
                    end
                end
            end
            S_RESULT: begin
                if (load_out) begin
                    m_valid_next = 1'b1;
                    m_port_next  = res_port_reg;
                    m_st_next    = res_st_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            ffound_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            ffound_reg  <= ffound_next;
            m_valid_reg <= m_valid_next;
        end
        kind_reg     <= kind_next;
        onep_reg     <= onep_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        key_reg      <= key_next;
        first_reg    <= first_next;
        wrap_reg     <= wrap_next;
        pidx_reg     <= pidx_next;
        fidx_reg     <= fidx_next;
        res_port_reg <= res_port_next;
        res_st_reg   <= res_st_next;
        m_port_reg   <= m_port_next;
        m_st_reg     <= m_st_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-PORT_W-2){1'b0}}, m_st_reg, m_port_reg};

    `EPA_ASSERT_IMP(a_fail_port_zero, aclk, aresetn,
        m_valid_reg && (m_st_reg == ST_NO_FREE || m_st_reg == ST_FULL), m_port_reg == '0)
    `EPA_ASSERT_NXT(a_scan_write_ends, aclk, aresetn,
        ram_we && state_reg == S_SCAN, state_reg == S_RESULT)
    `EPA_ASSERT_IMP(a_div_done_in_div, aclk, aresetn, div_done, state_reg == S_DIV)
    `EPA_ASSERT_NXT(a_accept_leaves_idle, aclk, aresetn, s_fire, !s_tready)

endmodule

`default_nettype wire
